// File: hdl/bucketed_key_value_map_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the bucketed key-value map
// Concurrent checks clocked on clk and disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef BUCKETED_KEY_VALUE_MAP_ASSERT_SVH
`define BUCKETED_KEY_VALUE_MAP_ASSERT_SVH

// Same-cycle implication.
`define BKV_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BKV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/bkv_pkg.sv
// ---------------------------------------------------------------------------
// bkv_pkg
// Transaction types, operation and status codes and state types shared by
// the bucketed key-value map modules.
// ---------------------------------------------------------------------------
package bkv_pkg;

  localparam int KEY_W = 31;
  localparam int VAL_W = 31;

  // operation codes; the unused code behaves as the empty query
  localparam logic [1:0] OP_SEARCH = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_EMPTY  = 2'd2;

  // result status codes
  localparam logic [2:0] ST_INSERTED = 3'd0;
  localparam logic [2:0] ST_REPLACED = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_HIT      = 3'd3;
  localparam logic [2:0] ST_MISS     = 3'd4;
  localparam logic [2:0] ST_EMPTY    = 3'd5;

  // request queue
  localparam int Q_DEPTH = 2;
  localparam int Q_PW    = $clog2(Q_DEPTH);

  typedef struct packed {
    logic [1:0]       op;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] new_value;
  } bkv_in_t;

  typedef struct packed {
    logic             hit;
    logic [VAL_W-1:0] read_value;
    logic [2:0]       status;
    logic             is_empty;
  } bkv_out_t;

  typedef enum logic [1:0] {
    FS_IDLE,
    FS_MOD,
    FS_PUSH
  } bkv_front_state_t;

  typedef enum logic [1:0] {
    BS_CLEAR,
    BS_IDLE,
    BS_CMP
  } bkv_back_state_t;

  // queue handshake seen by the front and the back
  typedef struct packed {
    logic full;
    logic empty;
  } bkv_q_stat_t;

endpackage

// File: hdl/bkv_front.sv
// ---------------------------------------------------------------------------
// bkv_front
// Accepts transactions and reduces the key to its bucket by multiplying with
// the reciprocal of the bucket count, then pushes the classified request
// into the queue.
// ---------------------------------------------------------------------------
module bkv_front #(
  parameter int BUCKETS = 16,
  parameter int BW      = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  bkv_pkg::bkv_in_t  in_item,
  input  logic              clearing,
  input  bkv_pkg::bkv_q_stat_t q_stat,
  output logic              push,
  output bkv_pkg::bkv_in_t  push_item,
  output logic [BW-1:0]     push_bucket
);

  localparam int KW = bkv_pkg::KEY_W;
  localparam int MW = KW + 1;
  localparam int PW = KW + MW;
  localparam int SH = KW + $clog2(BUCKETS);
  // ceil(2^SH / BUCKETS): the quotient is exact for every key of KW bits
  localparam logic [MW-1:0] RECIP =
    MW'(((64'd1 << SH) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS));

  bkv_pkg::bkv_front_state_t state_r, state_nxt;
  bkv_pkg::bkv_in_t          item_r;
  logic [PW-1:0]             prod_r, prod_nxt;
  logic [BW-1:0]             rem_r, rem_nxt, rem_step;
  logic                      accept;

  assign busy   = (state_r != bkv_pkg::FS_IDLE) || clearing;
  assign accept = start && !busy;

  // remainder: key minus quotient times the bucket count
  always_comb begin
    logic [KW-1:0] quo;
    logic [KW-1:0] diff;
    quo      = KW'(prod_r >> SH);
    diff     = item_r.key - KW'(quo * KW'(BUCKETS));
    rem_step = diff[BW-1:0];
  end

  always_comb begin
    state_nxt = state_r;
    prod_nxt  = prod_r;
    rem_nxt   = rem_r;
    push      = 1'b0;
    case (state_r)
      bkv_pkg::FS_IDLE: begin
        if (accept) begin
          prod_nxt  = PW'(in_item.key) * PW'(RECIP);
          rem_nxt   = '0;
          state_nxt = in_item.op[1] ? bkv_pkg::FS_PUSH : bkv_pkg::FS_MOD;
        end
      end
      bkv_pkg::FS_MOD: begin
        rem_nxt   = rem_step;
        state_nxt = bkv_pkg::FS_PUSH;
      end
      bkv_pkg::FS_PUSH: begin
        if (!q_stat.full) begin
          push      = 1'b1;
          state_nxt = bkv_pkg::FS_IDLE;
        end
      end
      default: begin
        state_nxt = bkv_pkg::FS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bkv_pkg::FS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_item;
    end
    prod_r <= prod_nxt;
    rem_r  <= rem_nxt;
  end

  assign push_item   = item_r;
  assign push_bucket = rem_r;

endmodule

// File: hdl/bkv_queue.sv
// ---------------------------------------------------------------------------
// bkv_queue
// Short request queue between the front and the back.
// ---------------------------------------------------------------------------
module bkv_queue #(
  parameter int DW = 68
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [DW-1:0] push_data,
  input  logic          pop,
  output logic [DW-1:0] head_data,
  output bkv_pkg::bkv_q_stat_t stat
);

  logic [DW-1:0]             slot_r [bkv_pkg::Q_DEPTH];
  logic [bkv_pkg::Q_PW-1:0]  wr_r, rd_r;
  logic [bkv_pkg::Q_PW:0]    cnt_r;

  assign stat.full  = (cnt_r == (bkv_pkg::Q_PW+1)'(bkv_pkg::Q_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign head_data  = slot_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= wr_r + 1'b1;
      end
      if (pop) begin
        rd_r <= rd_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_r] <= push_data;
    end
  end

endmodule

// File: hdl/bkv_back.sv
// ---------------------------------------------------------------------------
// bkv_back
// Holds the bucket store and carries out requests: a search or insert reads a
// bucket row and compares all ways, an insert writes it back; each emits one result.
// ---------------------------------------------------------------------------
module bkv_back #(
  parameter int BUCKETS = 16,
  parameter int WAYS    = 4,
  parameter int BW      = 4,
  parameter int WI      = 2,
  parameter int CW      = 7
) (
  input  logic             clk,
  input  logic             rst_n,
  input  bkv_pkg::bkv_q_stat_t q_stat,
  input  bkv_pkg::bkv_in_t q_item,
  input  logic [BW-1:0]    q_bucket,
  output logic             pop,
  output logic             clearing,
  output logic             out_strobe,
  output bkv_pkg::bkv_out_t out_item
);

  // bucket rows
  logic [WAYS-1:0]                        valid_mem [BUCKETS];
  logic [WAYS-1:0][bkv_pkg::KEY_W-1:0]    key_mem   [BUCKETS];
  logic [WAYS-1:0][bkv_pkg::VAL_W-1:0]    val_mem   [BUCKETS];

  logic [WAYS-1:0]                        vrow_r, vrow_w;
  logic [WAYS-1:0][bkv_pkg::KEY_W-1:0]    krow_r, krow_w;
  logic [WAYS-1:0][bkv_pkg::VAL_W-1:0]    arow_r, arow_w;

  bkv_pkg::bkv_back_state_t state_r, state_nxt;
  bkv_pkg::bkv_in_t   req_r;
  logic [BW-1:0]      bkt_r;
  logic [BW-1:0]      clr_r, clr_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  bkv_pkg::bkv_out_t  out_r, out_nxt;
  logic               strobe_r, strobe_nxt;
  logic               we, re;
  logic [BW-1:0]      wa;

  logic               found, free_found;
  logic [WI-1:0]      m_idx, f_idx;

  // lowest matching way and lowest free way
  always_comb begin
    found      = 1'b0;
    free_found = 1'b0;
    m_idx      = '0;
    f_idx      = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (vrow_r[w]) begin
        if (!found && (krow_r[w] == req_r.key)) begin
          found = 1'b1;
          m_idx = WI'(w);
        end
      end else if (!free_found) begin
        free_found = 1'b1;
        f_idx      = WI'(w);
      end
    end
  end

  always_comb begin
    state_nxt  = state_r;
    clr_nxt    = clr_r;
    count_nxt  = count_r;
    out_nxt    = out_r;
    strobe_nxt = 1'b0;
    pop        = 1'b0;
    re         = 1'b0;
    we         = 1'b0;
    wa         = bkt_r;
    vrow_w     = vrow_r;
    krow_w     = krow_r;
    arow_w     = arow_r;
    case (state_r)
      bkv_pkg::BS_CLEAR: begin
        we      = 1'b1;
        wa      = clr_r;
        vrow_w  = '0;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == BW'(BUCKETS - 1)) begin
          state_nxt = bkv_pkg::BS_IDLE;
        end
      end
      bkv_pkg::BS_IDLE: begin
        if (!q_stat.empty) begin
          pop = 1'b1;
          if (q_item.op[1]) begin
            strobe_nxt          = 1'b1;
            out_nxt.hit         = 1'b0;
            out_nxt.read_value  = '0;
            out_nxt.status      = bkv_pkg::ST_EMPTY;
            out_nxt.is_empty    = (count_r == '0);
          end else begin
            re        = 1'b1;
            state_nxt = bkv_pkg::BS_CMP;
          end
        end
      end
      bkv_pkg::BS_CMP: begin
        strobe_nxt         = 1'b1;
        out_nxt.hit        = 1'b0;
        out_nxt.read_value = '0;
        if (req_r.op == bkv_pkg::OP_SEARCH) begin
          if (found) begin
            out_nxt.hit        = 1'b1;
            out_nxt.read_value = arow_r[m_idx];
            out_nxt.status     = bkv_pkg::ST_HIT;
          end else begin
            out_nxt.status = bkv_pkg::ST_MISS;
          end
        end else if (found) begin
          we              = 1'b1;
          arow_w[m_idx]   = req_r.new_value;
          out_nxt.hit     = 1'b1;
          out_nxt.status  = bkv_pkg::ST_REPLACED;
        end else if (free_found) begin
          we              = 1'b1;
          vrow_w[f_idx]   = 1'b1;
          krow_w[f_idx]   = req_r.key;
          arow_w[f_idx]   = req_r.new_value;
          count_nxt       = count_r + 1'b1;
          out_nxt.status  = bkv_pkg::ST_INSERTED;
        end else begin
          out_nxt.status = bkv_pkg::ST_FULL;
        end
        out_nxt.is_empty = (count_nxt == '0);
        state_nxt        = bkv_pkg::BS_IDLE;
      end
      default: begin
        state_nxt = bkv_pkg::BS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= bkv_pkg::BS_CLEAR;
      clr_r    <= '0;
      count_r  <= '0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      clr_r    <= clr_nxt;
      count_r  <= count_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    if (pop) begin
      req_r <= q_item;
      bkt_r <= q_bucket;
    end
  end

  // store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      valid_mem[wa] <= vrow_w;
      key_mem[wa]   <= krow_w;
      val_mem[wa]   <= arow_w;
    end
    if (re) begin
      vrow_r <= valid_mem[q_bucket];
      krow_r <= key_mem[q_bucket];
      arow_r <= val_mem[q_bucket];
    end
  end

  assign clearing   = (state_r == bkv_pkg::BS_CLEAR);
  assign out_strobe = strobe_r;
  assign out_item   = out_r;

endmodule

// File: hdl/bucketed_key_value_map.sv
// ---------------------------------------------------------------------------
// bucketed_key_value_map
// Fixed-size key-value map with BUCKETS buckets of WAYS ways each.
// ---------------------------------------------------------------------------
// A transaction is taken on a rising edge with start high and busy low. Each
// transaction gives exactly one result, shown on out_item for one cycle with
// out_strobe high; the receiver cannot stall it, so take it when it shows.
// After reset the block sweeps the bucket store one row a cycle with busy
// held high. The key is multiplied by the reciprocal of the bucket count on
// the accepting edge. A search or insert then keeps busy high through
// FS_MOD, which forms the remainder, and FS_PUSH, which hands the request
// to the queue and waits while the queue is full; an empty query goes
// straight to FS_PUSH. No new transaction is taken until the request is
// pushed. The store side pops the request and reads the bucket row together,
// then compares all ways and writes back for an insert in the cycle after.
// out_strobe is registered from BS_CMP for a search or insert and from the
// pop for an empty query. Results come out in acceptance order.
// ---------------------------------------------------------------------------
module bucketed_key_value_map #(
  parameter int BUCKETS = 16,
  parameter int WAYS    = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  bkv_pkg::bkv_in_t  in_item,
  output logic              out_strobe,
  output bkv_pkg::bkv_out_t out_item
);

`include "bucketed_key_value_map_assert.svh"

  localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int WI = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int CW = $clog2(BUCKETS * WAYS + 1);
  localparam int DW = $bits(bkv_pkg::bkv_in_t) + BW;

  logic                 push, pop, clearing;
  bkv_pkg::bkv_in_t     push_item, q_item;
  logic [BW-1:0]        push_bucket, q_bucket;
  bkv_pkg::bkv_q_stat_t q_stat;

  // front: accept and reduce the key to a bucket
  bkv_front #(
    .BUCKETS (BUCKETS),
    .BW      (BW)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_item     (in_item),
    .clearing    (clearing),
    .q_stat      (q_stat),
    .push        (push),
    .push_item   (push_item),
    .push_bucket (push_bucket)
  );

  // hold classified requests until the store side is free
  bkv_queue #(
    .DW (DW)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data ({push_bucket, push_item}),
    .pop       (pop),
    .head_data ({q_bucket, q_item}),
    .stat      (q_stat)
  );

  // back: bucket store and read-modify-write
  bkv_back #(
    .BUCKETS (BUCKETS),
    .WAYS    (WAYS),
    .BW      (BW),
    .WI      (WI),
    .CW      (CW)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_stat     (q_stat),
    .q_item     (q_item),
    .q_bucket   (q_bucket),
    .pop        (pop),
    .clearing   (clearing),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

  // an accepted transaction closes the input for at least the next cycle
  `BKV_ASSERT_NEXT(a_busy_after_accept, start && !busy, busy, "busy low after accept")
  // only a hit or a replace reports a found key
  `BKV_ASSERT_NOW(a_hit_status, out_strobe && out_item.hit, (out_item.status == bkv_pkg::ST_HIT) || (out_item.status == bkv_pkg::ST_REPLACED), "hit with wrong status")
  // read data is zero except on a search hit
  `BKV_ASSERT_NOW(a_value_zero, out_strobe && (out_item.status != bkv_pkg::ST_HIT), out_item.read_value == '0, "read value on non-hit")
  // a fresh insert leaves the map non-empty
  `BKV_ASSERT_NOW(a_insert_nonempty, out_strobe && (out_item.status == bkv_pkg::ST_INSERTED), !out_item.is_empty, "empty after insert")
  // never pop an empty queue or push into a full one
  `BKV_ASSERT_NOW(a_queue_guard, push || pop, !(push && q_stat.full) && !(pop && q_stat.empty), "queue overrun")

endmodule
